[rtl/flc_pkg.sv]
// Shared types and codes for the full linear convolution block.
`default_nettype none

package flc_pkg;

    localparam int VAL_W  = 16;   // tap and sample width
    localparam int PROD_W = 32;   // one tap times one sample
    localparam int RES_W  = 40;   // accumulated result, wraps modulo 2^40
    localparam int ACT_W  = 2;

    typedef logic [ACT_W-1:0]         t_act;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RES_W-1:0]  t_res;

    localparam t_act ACT_CLEAR  = 2'd0;
    localparam t_act ACT_TAP    = 2'd1;
    localparam t_act ACT_SAMPLE = 2'd2;

    // per-cell control, driven from the top level
    typedef struct packed {
        logic adv;        // product stage moves on
        logic shift;      // sample line moves one cell along
        logic clr_hist;   // zero the sample line
        logic clr_tap;    // zero the tap
        logic load_tap;   // write this cell's tap
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/flc_in_if.sv]
// Input channel: action, value and last with valid/ready.
`default_nettype none

interface flc_in_if;
    import flc_pkg::*;

    logic valid;
    logic ready;
    t_act action;
    t_val value;
    logic last;

    modport source (output valid, output action, output value, output last, input ready);
    modport sink   (input valid, input action, input value, input last, output ready);
endinterface

`default_nettype wire

[rtl/flc_out_if.sv]
// Output channel: result and last_out with valid/ready.
`default_nettype none

interface flc_out_if;
    import flc_pkg::*;

    logic valid;
    logic ready;
    t_res result;
    logic last_out;

    modport source (output valid, output result, output last_out, input ready);
    modport sink   (input valid, input result, input last_out, output ready);
endinterface

`default_nettype wire

[rtl/full_linear_convolution.sv]
// Full linear convolution: chain of tap cells feeding a registered adder tree.
//
//  channel  dir  payload                        transfer when
//  -------  ---  -----------------------------  -----------------------
//  i_in     in   action[1:0] value[15:0] last   i_in.valid & i_in.ready
//  o_out    out  result[39:0] last_out          o_out.valid & o_out.ready
//
// A sample is taken every cycle while i_in.ready is high; the pipeline
// depth is the product register plus the adder tree.
// The sample marked last is followed by tap_count-1 tail zeros that are
// fed in; i_in.ready stays low during that flush.
// Reset (synchronous, active low) zeroes the taps, the count and the history.
// A stall on o_out freezes the whole pipeline and drops i_in.ready.
`default_nettype none

module full_linear_convolution #(
    parameter int MAX_TAPS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    flc_in_if.sink    i_in,
    flc_out_if.source o_out
);
    import flc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int LVL   = $clog2(MAX_TAPS);

    localparam logic [CNT_W-1:0] TAPS_MAX = CNT_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_tap_count;
    logic [CNT_W-1:0] n_tap_count;
    logic [CNT_W-1:0] r_flush_cnt;   // tail results still to inject
    logic [CNT_W-1:0] n_flush_cnt;
    logic [LVL:0]     r_vld;         // one bit per pipeline stage
    logic [LVL:0]     n_vld;
    logic [LVL:0]     r_lst;
    logic [LVL:0]     n_lst;

    logic             adv;
    logic             flushing;
    logic             acc;
    logic             acc_clear;
    logic             acc_tap;
    logic             acc_smp;
    logic             tap_we;
    logic             inject;
    logic             inj_last;
    logic             hist_clr;
    logic             shift;
    logic [CNT_W-1:0] tail;
    t_val             cur;

    // the last stage is the output register; everything moves when it frees
    assign adv      = !r_vld[LVL] || o_out.ready;
    assign flushing = (r_flush_cnt != '0);

    assign i_in.ready = adv && !flushing;
    assign acc        = i_in.valid && i_in.ready;
    assign acc_clear  = acc && (i_in.action == ACT_CLEAR);
    assign acc_tap    = acc && (i_in.action == ACT_TAP);
    assign acc_smp    = acc && (i_in.action == ACT_SAMPLE);

    // taps beyond the count are zero, so the products need no count; the tail length does
    assign tail   = (r_tap_count > ONE) ? (r_tap_count - ONE) : '0;
    assign tap_we = acc_tap && (r_tap_count < TAPS_MAX);

    // a new item enters the cells: a real sample or a tail zero
    assign inject   = acc_smp || (flushing && adv);
    assign cur      = flushing ? t_val'(0) : i_in.value;
    assign inj_last = flushing ? (r_flush_cnt == ONE)
                               : (i_in.last && (r_tap_count <= ONE));

    // history is wiped by a clear and after the final result of a signal
    assign hist_clr = acc_clear
                   || (acc_smp && i_in.last && (tail == '0))
                   || (flushing && adv && (r_flush_cnt == ONE));
    assign shift    = inject && !hist_clr;

    always_comb begin
        n_tap_count = r_tap_count;
        if (acc_clear) begin
            n_tap_count = '0;
        end else if (tap_we) begin
            n_tap_count = r_tap_count + ONE;
        end

        n_flush_cnt = r_flush_cnt;
        if (acc_smp && i_in.last) begin
            n_flush_cnt = tail;
        end else if (flushing && adv) begin
            n_flush_cnt = r_flush_cnt - ONE;
        end

        n_vld = r_vld;
        n_lst = r_lst;
        if (adv) begin
            n_vld[0] = inject;
            n_lst[0] = inj_last;
            for (int i = 1; i <= LVL; i++) begin
                n_vld[i] = r_vld[i-1];
                n_lst[i] = r_lst[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_flush_cnt <= '0;
            r_vld       <= '0;
        end else begin
            r_tap_count <= n_tap_count;
            r_flush_cnt <= n_flush_cnt;
            r_vld       <= n_vld;
        end
    end

    // flag pipeline is payload and needs no reset
    always_ff @(posedge i_clk) begin
        r_lst <= n_lst;
    end

    // ---------------------------------------------------------------
    // Cell chain: cell j holds tap j and history entry j; its product
    // uses the sample arriving from cell j-1 (the new sample for cell 0)
    // ---------------------------------------------------------------
    t_val      w_x    [MAX_TAPS];
    t_prod     w_prod [MAX_TAPS];
    t_cell_ctl w_ctl  [MAX_TAPS];
    t_res      w_sum;

    assign w_x[0] = cur;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        assign w_ctl[j] = '{
            adv:      adv,
            shift:    shift,
            clr_hist: hist_clr,
            clr_tap:  acc_clear,
            load_tap: tap_we && (r_tap_count == CNT_W'(j))
        };

        if (j < MAX_TAPS - 1) begin : g_mid
            flc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_tap   (i_in.value),
                .i_x     (w_x[j]),
                .o_x     (w_x[j+1]),
                .o_prod  (w_prod[j])
            );
        end else begin : g_end
            // oldest history entry is never read again
            flc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_tap   (i_in.value),
                .i_x     (w_x[j]),
                .o_x     (),
                .o_prod  (w_prod[j])
            );
        end
    end

    flc_adder_tree #(
        .N (MAX_TAPS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_leaf (w_prod),
        .o_sum  (w_sum)
    );

    assign o_out.valid    = r_vld[LVL];
    assign o_out.result   = w_sum;
    assign o_out.last_out = r_lst[LVL];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_tap_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_count <= TAPS_MAX)
        else $error("tap count beyond maximum");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(r_vld) && $stable(r_flush_cnt))
        else $error("pipeline moved during output stall");

    a_flush_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_smp && i_in.last |=> r_flush_cnt == $past(tail))
        else $error("flush length differs from tap count minus one");

    a_flush_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flushing && adv |=> r_flush_cnt == $past(r_flush_cnt) - ONE)
        else $error("flush counter skipped");

    a_flush_final_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flushing && adv && r_flush_cnt == ONE |=> r_vld[0] && r_lst[0])
        else $error("final tail result not flagged");

endmodule

`default_nettype wire

[rtl/flc_cell.sv]
// One convolution cell: a tap, one sample of history and a registered product.
`default_nettype none

module flc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  flc_pkg::t_cell_ctl i_ctl,
    input  flc_pkg::t_val     i_tap,
    input  flc_pkg::t_val     i_x,
    output flc_pkg::t_val     o_x,
    output flc_pkg::t_prod    o_prod
);
    import flc_pkg::*;

    t_val  r_tap;
    t_val  r_x;
    t_prod r_prod;
    t_prod n_prod;

    // i_x is the sample this tap sees for the item now entering
    assign n_prod = PROD_W'(r_tap) * PROD_W'(i_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
            r_x   <= '0;
        end else begin
            if (i_ctl.clr_tap) begin
                r_tap <= '0;
            end else if (i_ctl.load_tap) begin
                r_tap <= i_tap;
            end
            if (i_ctl.clr_hist) begin
                r_x <= '0;
            end else if (i_ctl.shift) begin
                r_x <= i_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_x    = r_x;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/flc_adder_tree.sv]
// Registered binary adder tree over the cell products.
`default_nettype none

module flc_adder_tree #(
    parameter int N = 64
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  flc_pkg::t_prod i_leaf [N],
    output flc_pkg::t_res  o_sum
);
    import flc_pkg::*;

    localparam int LVL    = $clog2(N);
    localparam int LEAVES = 1 << LVL;

    if (LVL == 0) begin : g_single
        assign o_sum = RES_W'(i_leaf[0]);
    end else begin : g_tree
        t_res w_leaf [LEAVES];
        t_res r_node [1:LEAVES-1];   // heap order, node 1 is the root

        for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
            if (i < N) begin : g_used
                assign w_leaf[i] = RES_W'(i_leaf[i]);
            end else begin : g_pad
                assign w_leaf[i] = '0;
            end
        end

        for (genvar i = 1; i < LEAVES; i++) begin : g_node
            t_res w_lo;
            t_res w_hi;
            t_res n_sum;
            if (2 * i >= LEAVES) begin : g_bottom
                assign w_lo = w_leaf[2*i - LEAVES];
                assign w_hi = w_leaf[2*i + 1 - LEAVES];
            end else begin : g_inner
                assign w_lo = r_node[2*i];
                assign w_hi = r_node[2*i + 1];
            end
            assign n_sum = w_lo + w_hi;

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_node[i] <= n_sum;
                end
            end
        end

        assign o_sum = r_node[1];
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the full linear convolution block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import flc_pkg::*;

    localparam int   MAX_TAPS    = 64;
    localparam int   PIPE_LAT    = 1 + $clog2(MAX_TAPS);  // product reg plus adder tree
    localparam int   CYCLE_LIMIT = 200000;
    localparam t_act ACT_UNUSED  = 2'd3;                  // spare code, block ignores it

    // one command on the input channel
    typedef struct packed {
        t_act action;
        t_val value;
        logic last;
    } t_command;

    // one convolution output as it should leave the block
    typedef struct packed {
        t_res result;
        logic last_out;
    } t_conv_out;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    flc_in_if  in_ch ();
    flc_out_if out_ch ();

    full_linear_convolution #(
        .MAX_TAPS (MAX_TAPS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Commands waiting to be offered, and convolution outputs still owed by the block.
    t_command  command_q[$];
    t_conv_out expected_y[$];

    int err_cnt   = 0;
    int item_cnt  = 0;   // commands queued, spare-code commands not counted
    int cycle_cnt = 0;
    int tx_idle   = 15;  // percent of cycles the sender holds back
    int rx_idle   = 48;  // percent of cycles the receiver stalls

    // Own copy of the filter state: kernel, how many taps are loaded, and the
    // sample line (entry 0 is the most recent previous sample).
    t_val kern [MAX_TAPS];
    t_val hist [MAX_TAPS-1];
    int   tap_cnt;

    // Sum of products with cur as the newest sample, then cur moves into the line.
    function automatic t_res conv_output(t_val cur);
        t_res  acc;
        t_prod prod;
        acc = '0;
        for (int j = 0; j < tap_cnt; j++) begin
            prod = kern[j] * ((j == 0) ? cur : hist[j-1]);
            acc  = acc + t_res'(prod);
        end
        for (int k = MAX_TAPS - 2; k > 0; k--)
            hist[k] = hist[k-1];
        hist[0] = cur;
        return acc;
    endfunction

    // Applies one accepted command to the filter state and queues the outputs it owes.
    function automatic void fir_command(t_act act, t_val val, logic lst);
        t_conv_out y;
        int        tail;
        case (act)
            ACT_CLEAR: begin
                tap_cnt = 0;
                foreach (kern[i]) kern[i] = '0;
                foreach (hist[i]) hist[i] = '0;
            end
            ACT_TAP: begin
                // a full kernel silently drops further taps
                if (tap_cnt < MAX_TAPS) begin
                    kern[tap_cnt] = val;
                    tap_cnt++;
                end
            end
            ACT_SAMPLE: begin
                // with no taps or a single tap the sample output is the final one
                y.result   = conv_output(val);
                y.last_out = lst && (tap_cnt <= 1);
                expected_y.insert(expected_y.size(), y);
                if (lst) begin
                    // tail flush: zeros fed in until the kernel has slid off the end
                    tail = (tap_cnt > 1) ? tap_cnt - 1 : 0;
                    for (int t = 0; t < tail; t++) begin
                        y.result   = conv_output('0);
                        y.last_out = (t == tail - 1);
                        expected_y.insert(expected_y.size(), y);
                    end
                    foreach (hist[i]) hist[i] = '0;
                end
            end
            default: ;  // spare code: no output, no change of state
        endcase
    endfunction

    function automatic void add_command(t_act act, t_val val, logic lst);
        t_command c;
        c.action = act;
        c.value  = val;
        c.last   = lst;
        command_q.insert(command_q.size(), c);
        if (act != ACT_UNUSED)
            item_cnt++;
    endfunction

    // Values lean towards the extremes so that the largest sums turn up often.
    function automatic t_val rand_value();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sh0001;
            default: return t_val'($urandom);
        endcase
    endfunction

    // One signal: usually a fresh kernel, then a run of samples ending on last.
    // Now and then a spare-code command, a tap slipped in mid-signal, or a
    // signal that never sees last.
    task automatic add_signal();
        int n_taps;
        int n_samp;
        if ($urandom_range(9) != 0)
            add_command(ACT_CLEAR, rand_value(), 1'($urandom_range(1)));
        if ($urandom_range(19) == 0)
            n_taps = $urandom_range(66, 60);  // fill the kernel, overflow it at times
        else
            n_taps = $urandom_range(8);
        repeat (n_taps)
            add_command(ACT_TAP, rand_value(), 1'($urandom_range(1)));
        n_samp = $urandom_range(12, 1);
        for (int s = 0; s < n_samp; s++) begin
            if ($urandom_range(29) == 0)
                add_command(ACT_UNUSED, rand_value(), 1'($urandom_range(1)));
            if ($urandom_range(39) == 0)
                add_command(ACT_TAP, rand_value(), 1'b0);
            add_command(ACT_SAMPLE, rand_value(),
                        (s == n_samp - 1) ? 1'($urandom_range(9) != 0) : 1'b0);
        end
    endtask

    // Sampled at the falling edge so the clocked blocks have settled.
    task automatic wait_drained();
        while (command_q.size() != 0 || in_ch.valid || expected_y.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: offers the next command when the channel is free, holds it
    // steady until the transfer, and feeds every transfer to the predictor.
    always @(posedge i_clk) begin : drive
        t_command nxt;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.action <= ACT_CLEAR;
            in_ch.value  <= '0;
            in_ch.last   <= 1'b0;
            fir_command(ACT_CLEAR, '0, 1'b0);
        end else begin
            if (in_ch.valid && in_ch.ready)
                fir_command(in_ch.action, in_ch.value, in_ch.last);
            if (!in_ch.valid || in_ch.ready) begin
                if (command_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    nxt = command_q[0];
                    command_q.delete(0);
                    in_ch.valid  <= 1'b1;
                    in_ch.action <= nxt.action;
                    in_ch.value  <= nxt.value;
                    in_ch.last   <= nxt.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, each output transfer checked against
    // the oldest owed output.
    always @(posedge i_clk) begin : check
        t_conv_out y;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_y.size() == 0) begin
                    $error("unexpected output: result %0d last_out %0b",
                           out_ch.result, out_ch.last_out);
                    err_cnt++;
                end else begin
                    y = expected_y[0];
                    expected_y.delete(0);
                    if (out_ch.result !== y.result) begin
                        $error("result: expected %0d, actual %0d", y.result, out_ch.result);
                        err_cnt++;
                    end
                    if (out_ch.last_out !== y.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               y.last_out, out_ch.last_out);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty kernel, spare code, single tap at the extremes,
        // a three-tap kernel that grows mid-signal, largest positive products.
        add_command(ACT_SAMPLE, 16'sh7fff, 1'b0);
        add_command(ACT_SAMPLE, 16'sh8000, 1'b1);   // empty kernel, lone zero is final
        add_command(ACT_UNUSED, -16'sh0001, 1'b1);
        add_command(ACT_TAP,    16'sh8000, 1'b1);   // last is meaningless on a tap
        add_command(ACT_SAMPLE, 16'sh8000, 1'b1);   // single tap, flagged at once
        add_command(ACT_TAP,    16'sh7fff, 1'b0);
        add_command(ACT_TAP,    -16'sh0001, 1'b0);
        add_command(ACT_SAMPLE, 16'sh7fff, 1'b0);
        add_command(ACT_SAMPLE, 16'sh8000, 1'b0);
        add_command(ACT_TAP,    16'sh0001, 1'b0);   // kernel grows, history kept
        add_command(ACT_SAMPLE, -16'sh0001, 1'b1);
        add_command(ACT_CLEAR,  -16'sh0001, 1'b1);
        add_command(ACT_TAP,    16'sh7fff, 1'b0);
        add_command(ACT_TAP,    16'sh7fff, 1'b0);
        add_command(ACT_SAMPLE, 16'sh7fff, 1'b0);
        add_command(ACT_SAMPLE, 16'sh7fff, 1'b1);
        add_command(ACT_CLEAR,  16'sh0000, 1'b0);

        // Sender idles lightly, receiver heavily.
        while (item_cnt < 130)
            add_signal();
        wait_drained();

        // The other way round.
        tx_idle = 48;
        rx_idle = 15;
        while (item_cnt < 265)
            add_signal();
        wait_drained();

        // Full rate on both sides.
        tx_idle = 0;
        rx_idle = 0;
        while (item_cnt < 400)
            add_signal();
        wait_drained();

        // let any stray output surface
        repeat (4 * PIPE_LAT) @(negedge i_clk);

        if (err_cnt == 0 && expected_y.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
